[src/sce_pkg.sv]
// Shared types and constants of the stack calculator engine.
package sce_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int FRAC_W      = 16;
  localparam int DIV_NUM_W   = VAL_W + FRAC_W;
  localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_POP  = 3'd1;
  localparam logic [2:0] CMD_ADD  = 3'd2;
  localparam logic [2:0] CMD_SUB  = 3'd3;
  localparam logic [2:0] CMD_MUL  = 3'd4;
  localparam logic [2:0] CMD_DIV  = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNDER   = 2'd1;
  localparam logic [1:0] ST_OVER    = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]              command;
    logic signed [VAL_W-1:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [1:0]              status;
    logic [6:0]              depth_after;
    logic                    saturated;
  } out_rsp_t;

endpackage

[src/stack_calculator_engine_unit.sv]
// Flow: S_IDLE takes a request, S_READ reads its operands, mul passes S_MUL, div waits
//   in S_DIV on the 48-step divider, S_DONE writes back and loads the output register.
//   One request at a time; the next can be taken in the cycle after the result is loaded.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, synchronous, active low) clears the depth count, FSM and output valid;
//   the value memory is not cleared, entries are always pushed before they are read.
module stack_calculator_engine_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sce_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sce_pkg::out_rsp_t out_data
);

  // One-hot controller states.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for a request
    S_READ = 5'b00010,  // top two entries arrive from the memory
    S_MUL  = 5'b00100,  // product registered, round and clamp
    S_DIV  = 5'b01000,  // divider iterating
    S_DONE = 5'b10000   // write back, load output register
  } state_t;

  state_t state_r, state_nxt;

  // Latched request.
  logic [2:0]                         cmd_r;
  logic signed [sce_pkg::VAL_W-1:0]   pval_r;

  // Stack pointer (count of stored values) and its value after the command.
  logic [sce_pkg::CNT_W-1:0]          depth_r;
  logic [sce_pkg::CNT_W-1:0]          depth_new_r;

  // Value store: one write port, two registered read ports.
  logic [sce_pkg::VAL_W-1:0]          mem [sce_pkg::STACK_DEPTH];
  logic signed [sce_pkg::VAL_W-1:0]   rd_a_r;   // top (operand a)
  logic signed [sce_pkg::VAL_W-1:0]   rd_b_r;   // next below (operand b)
  logic [sce_pkg::ADDR_W-1:0]         ra, rb;

  // Result being built.
  logic signed [sce_pkg::VAL_W-1:0]   res_r;
  logic [1:0]                         status_r;
  logic                               sat_r;
  logic                               wr_en_r;
  logic [sce_pkg::ADDR_W-1:0]         wr_addr_r;
  logic [sce_pkg::VAL_W-1:0]          wr_data;
  logic                               mem_we;

  logic signed [2*sce_pkg::VAL_W-1:0] prod_r;
  logic signed [2*sce_pkg::VAL_W-1:0] prod_c;
  logic signed [2*sce_pkg::VAL_W-1:0] rnd_sum;
  logic signed [2*sce_pkg::VAL_W-1:0] rnd_sh;
  logic                               mul_ovf;
  logic signed [sce_pkg::VAL_W-1:0]   mul_res;

  logic signed [sce_pkg::VAL_W:0]     add_sum;
  logic signed [sce_pkg::VAL_W:0]     sub_dif;
  logic                               add_ovf;
  logic                               sub_ovf;

  logic                               out_valid_r;
  sce_pkg::out_rsp_t                  out_data_r;

  logic accept;
  logic fin;
  logic is_full, is_empty, is_short, is_bin, a_zero;
  logic div_start, div_done, div_sat;
  logic signed [sce_pkg::VAL_W-1:0]   div_q;

  // ---------------------------------------------------------------
  // Handshake: one request in flight; results leave via out register
  // ---------------------------------------------------------------
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign fin      = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Decode flags, valid in S_READ.
  assign is_full  = (depth_r == sce_pkg::CNT_W'(sce_pkg::STACK_DEPTH));
  assign is_empty = (depth_r == '0);
  assign is_short = (depth_r < sce_pkg::CNT_W'(2));
  assign is_bin   = (cmd_r == sce_pkg::CMD_ADD) || (cmd_r == sce_pkg::CMD_SUB) ||
                    (cmd_r == sce_pkg::CMD_MUL) || (cmd_r == sce_pkg::CMD_DIV);
  assign a_zero   = (rd_a_r == '0);

  assign div_start = (state_r == S_READ) && (cmd_r == sce_pkg::CMD_DIV) &&
                     !is_short && !a_zero;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_READ;
      S_READ: begin
        if (is_bin && !is_short && (cmd_r == sce_pkg::CMD_MUL)) state_nxt = S_MUL;
        else if (div_start)                                        state_nxt = S_DIV;
        else                                                       state_nxt = S_DONE;
      end
      S_MUL:  state_nxt = S_DONE;
      S_DIV:  if (div_done) state_nxt = S_DONE;
      S_DONE: if (fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) depth_r <= depth_new_r;
      if (fin)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // Value memory. Reads are issued on the accepting edge; the write of
  // the previous request completed in S_DONE, so no overlap is possible.
  // ---------------------------------------------------------------
  assign ra      = depth_r[sce_pkg::ADDR_W-1:0] - sce_pkg::ADDR_W'(1);
  assign rb      = depth_r[sce_pkg::ADDR_W-1:0] - sce_pkg::ADDR_W'(2);
  assign wr_data = (cmd_r == sce_pkg::CMD_PUSH) ? pval_r : res_r;
  assign mem_we  = fin && wr_en_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr_r] <= wr_data;
    if (accept) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  // ---------------------------------------------------------------
  // Arithmetic
  // ---------------------------------------------------------------
  assign add_sum = {rd_b_r[sce_pkg::VAL_W-1], rd_b_r} + {rd_a_r[sce_pkg::VAL_W-1], rd_a_r};
  assign sub_dif = {rd_b_r[sce_pkg::VAL_W-1], rd_b_r} - {rd_a_r[sce_pkg::VAL_W-1], rd_a_r};
  assign add_ovf = add_sum[sce_pkg::VAL_W] ^ add_sum[sce_pkg::VAL_W-1];
  assign sub_ovf = sub_dif[sce_pkg::VAL_W] ^ sub_dif[sce_pkg::VAL_W-1];

  assign prod_c = rd_a_r * rd_b_r;

  // Round to nearest, ties up: add half an LSB, then floor shift.
  assign rnd_sum = prod_r + (2*sce_pkg::VAL_W)'(32768);
  assign rnd_sh  = rnd_sum >>> sce_pkg::FRAC_W;
  assign mul_ovf = !((&rnd_sh[2*sce_pkg::VAL_W-1:sce_pkg::VAL_W-1]) ||
                     !(|rnd_sh[2*sce_pkg::VAL_W-1:sce_pkg::VAL_W-1]));
  assign mul_res = mul_ovf ? (rnd_sh[2*sce_pkg::VAL_W-1] ? sce_pkg::VAL_MIN : sce_pkg::VAL_MAX)
                           : rnd_sh[sce_pkg::VAL_W-1:0];

  sce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_b_r),
    .divisor  (rd_a_r),
    .done     (div_done),
    .quotient (div_q),
    .sat      (div_sat)
  );

  // ---------------------------------------------------------------
  // Result build-up
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.command;
      pval_r <= in_data.push_value;
    end

    if (state_r == S_READ) begin
      status_r    <= sce_pkg::ST_OK;
      res_r       <= '0;
      sat_r       <= 1'b0;
      wr_en_r     <= 1'b0;
      wr_addr_r   <= rb;
      depth_new_r <= depth_r;
      prod_r      <= prod_c;
      if (cmd_r == sce_pkg::CMD_PUSH) begin
        if (is_full) begin
          status_r <= sce_pkg::ST_OVER;
        end else begin
          wr_en_r     <= 1'b1;
          wr_addr_r   <= depth_r[sce_pkg::ADDR_W-1:0];
          depth_new_r <= depth_r + 1'b1;
        end
      end else if (cmd_r == sce_pkg::CMD_POP) begin
        if (is_empty) begin
          status_r <= sce_pkg::ST_UNDER;
        end else begin
          res_r       <= rd_a_r;
          depth_new_r <= depth_r - 1'b1;
        end
      end else if (is_bin) begin
        if (is_short) begin
          // Whatever was there is consumed.
          status_r    <= sce_pkg::ST_UNDER;
          depth_new_r <= '0;
        end else if ((cmd_r == sce_pkg::CMD_DIV) && a_zero) begin
          status_r    <= sce_pkg::ST_DIVZERO;
          depth_new_r <= depth_r - sce_pkg::CNT_W'(2);
        end else begin
          wr_en_r     <= 1'b1;
          depth_new_r <= depth_r - 1'b1;
          if (cmd_r == sce_pkg::CMD_ADD) begin
            sat_r <= add_ovf;
            res_r <= add_ovf ? (add_sum[sce_pkg::VAL_W] ? sce_pkg::VAL_MIN : sce_pkg::VAL_MAX)
                             : add_sum[sce_pkg::VAL_W-1:0];
          end else if (cmd_r == sce_pkg::CMD_SUB) begin
            sat_r <= sub_ovf;
            res_r <= sub_ovf ? (sub_dif[sce_pkg::VAL_W] ? sce_pkg::VAL_MIN : sce_pkg::VAL_MAX)
                             : sub_dif[sce_pkg::VAL_W-1:0];
          end
        end
      end
    end else if (state_r == S_MUL) begin
      res_r <= mul_res;
      sat_r <= mul_ovf;
    end else if ((state_r == S_DIV) && div_done) begin
      res_r <= div_q;
      sat_r <= div_sat;
    end

    if (fin) begin
      out_data_r.result_value <= res_r;
      out_data_r.status       <= status_r;
      out_data_r.depth_after  <= 7'(depth_new_r);
      out_data_r.saturated    <= sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= sce_pkg::CNT_W'(sce_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_depth_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (depth_r != $past(depth_r))) |-> $past(state_r == S_DONE))
    else $error("depth changed outside write-back");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (rd_a_r != '0))
    else $error("divider started with zero divisor");
`endif

endmodule

[src/sce_div.sv]
// Bit-serial restoring divider for the Q16.16 quotient (b * 2^16) / a, saturated.
module sce_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [sce_pkg::VAL_W-1:0]  dividend,
  input  logic signed [sce_pkg::VAL_W-1:0]  divisor,
  output logic                              done,
  output logic signed [sce_pkg::VAL_W-1:0]  quotient,
  output logic                              sat
);

  logic                              busy_r;
  logic                              done_r;
  logic [sce_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [sce_pkg::VAL_W-1:0]         rem_r;
  logic [sce_pkg::DIV_NUM_W-1:0]     quo_r;
  logic [sce_pkg::VAL_W-1:0]         dvs_r;
  logic                              neg_r;

  logic [sce_pkg::VAL_W:0]           rem_sh;
  logic [sce_pkg::VAL_W:0]           trial;
  logic                              ge;
  logic [sce_pkg::VAL_W-1:0]         mag_b;
  logic [sce_pkg::VAL_W-1:0]         mag_a;
  logic                              big_pos;
  logic                              big_neg;

  assign mag_b  = dividend[sce_pkg::VAL_W-1] ? (~dividend + 1'b1) : dividend;
  assign mag_a  = divisor[sce_pkg::VAL_W-1]  ? (~divisor + 1'b1)  : divisor;
  assign rem_sh = {rem_r, quo_r[sce_pkg::DIV_NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});
  assign trial  = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == sce_pkg::DIV_CNT_W'(sce_pkg::DIV_NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= {mag_b, {sce_pkg::FRAC_W{1'b0}}};
      dvs_r <= mag_a;
      neg_r <= dividend[sce_pkg::VAL_W-1] ^ divisor[sce_pkg::VAL_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? trial[sce_pkg::VAL_W-1:0] : rem_sh[sce_pkg::VAL_W-1:0];
      quo_r <= {quo_r[sce_pkg::DIV_NUM_W-2:0], ge};
    end
  end

  // Positive results clamp above 2^31-1, negative ones below -2^31.
  assign big_pos = |quo_r[sce_pkg::DIV_NUM_W-1:sce_pkg::VAL_W-1];
  assign big_neg = (|quo_r[sce_pkg::DIV_NUM_W-1:sce_pkg::VAL_W]) |
                   (quo_r[sce_pkg::VAL_W-1] & (|quo_r[sce_pkg::VAL_W-2:0]));

  always_comb begin
    if (neg_r) begin
      sat      = big_neg;
      quotient = big_neg ? sce_pkg::VAL_MIN : (~quo_r[sce_pkg::VAL_W-1:0] + 1'b1);
    end else begin
      sat      = big_pos;
      quotient = big_pos ? sce_pkg::VAL_MAX : quo_r[sce_pkg::VAL_W-1:0];
    end
  end

  assign done = done_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider restarted while busy");
`endif

endmodule

[test/tb_top.sv]
// Self-checking testbench for the stack calculator engine with directed, full-stack and random tests.
module tb_top;
  import sce_pkg::*;

  // Command codes the block leaves unused; it must answer them with status ok
  // and leave the stack alone.
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Q16.16 constants for the directed part.
  localparam logic signed [VAL_W-1:0] Q_FIVE    = 32'sh0005_0000;
  localparam logic signed [VAL_W-1:0] Q_HALF    = 32'sh0000_8000;
  localparam logic signed [VAL_W-1:0] Q_LSB_NEG = -32'sd1;
  localparam logic signed [VAL_W-1:0] Q_ZERO    = 32'sd0;

  // Room left for the drain after the slowest request (divide).
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_REQUESTS = 1150;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_req_t   in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_rsp_t  out_data;

  // Shadow of the calculator: value stack and fill count, updated at each
  // accepted request, in acceptance order.
  logic signed [VAL_W-1:0] calc_stack [STACK_DEPTH];
  int                      calc_depth = 0;

  // Responses predicted but not yet seen on the output channel, oldest first.
  out_rsp_t awaited_results [$];

  int error_count = 0;

  // Receiver back-pressure: a short random stall drawn after every accepted
  // response, plus a long hold that a test may ask for.
  int stall_left  = 0;
  int hold_cycles = 0;

  // When set, neither side idles, giving back-to-back stretches.
  bit calm = 1'b0;

  stack_calculator_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1000000;
    $display("stack_calculator_engine_unit regression: fail");
    $finish;
  end

  // Clamp a wide result to the signed 32-bit range, flagging the clamp.
  function automatic logic signed [VAL_W-1:0] clamp_q16(longint wide, output logic sat);
    sat = 1'b0;
    if (wide > longint'(VAL_MAX)) begin
      sat = 1'b1;
      return VAL_MAX;
    end
    if (wide < longint'(VAL_MIN)) begin
      sat = 1'b1;
      return VAL_MIN;
    end
    return wide[VAL_W-1:0];
  endfunction

  // Apply one command to the shadow stack and return the response it must
  // produce.
  function automatic out_rsp_t evaluate_command(in_req_t req);
    out_rsp_t rsp;
    longint   a;
    longint   b;
    longint   wide;
    logic     sat;
    rsp  = '0;
    sat  = 1'b0;
    wide = 0;
    rsp.status = ST_OK;
    case (req.command)
      CMD_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          rsp.status = ST_OVER;
        end else begin
          calc_stack[calc_depth] = req.push_value;
          calc_depth++;
        end
      end
      CMD_POP: begin
        if (calc_depth == 0) begin
          rsp.status = ST_UNDER;
        end else begin
          calc_depth--;
          rsp.result_value = calc_stack[calc_depth];
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (calc_depth < 2) begin
          // short operand list: whatever was there is consumed
          calc_depth = 0;
          rsp.status = ST_UNDER;
        end else begin
          a = calc_stack[calc_depth-1];
          b = calc_stack[calc_depth-2];
          calc_depth -= 2;
          case (req.command)
            CMD_ADD: wide = b + a;
            CMD_SUB: wide = b - a;
            // round to nearest, ties up: add half an LSB, then floor shift
            CMD_MUL: wide = (a * b + 64'sd32768) >>> FRAC_W;
            default: begin
              if (a == 0) rsp.status = ST_DIVZERO;
              else wide = (b * 64'sd65536) / a;
            end
          endcase
          if (rsp.status != ST_DIVZERO) begin
            rsp.result_value = clamp_q16(wide, sat);
            calc_stack[calc_depth] = rsp.result_value;
            calc_depth++;
          end
        end
      end
      default: ;
    endcase
    rsp.depth_after = calc_depth[6:0];
    rsp.saturated   = sat;
    return rsp;
  endfunction

  function automatic void compare_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      error_count++;
    end
  endfunction

  // Response checker: every accepted response is matched against the oldest
  // prediction.
  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("response with none outstanding: value %0d status %0d depth %0d",
               $signed(out_data.result_value), out_data.status, out_data.depth_after);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("result_value", $signed(want.result_value),
                      $signed(out_data.result_value));
        compare_field("status", want.status, out_data.status);
        compare_field("depth_after", want.depth_after, out_data.depth_after);
        compare_field("saturated", want.saturated, out_data.saturated);
      end
      stall_left = calm ? 0 : $urandom_range(0, 9);
    end
  end

  // Receiver: drives out_stall at falling edges; the long hold wins over the
  // per-response stall.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one request and wait until it is taken. Entered and left at a
  // falling edge; valid stays high when no gap is drawn.
  task automatic send_request(logic [2:0] cmd, logic signed [VAL_W-1:0] value);
    int     gap;
    in_req_t req;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.command    = cmd;
    req.push_value = value;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(evaluate_command(req));
    @(negedge clk);
  endtask

  // Push values: extremes, zero (feeds divide by zero), small and medium
  // magnitudes (rounding and product saturation) and full-range noise.
  function automatic logic signed [VAL_W-1:0] random_q16();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return Q_ZERO;
      3, 4:    return $urandom;
      5, 6:    return $urandom_range(0, 32'h0200_0000) - 32'sh0100_0000;
      default: return $urandom_range(0, 32'h000A_0000) - 32'sh0005_0000;
    endcase
  endfunction

  // Extremes, every command and the underflow and divide-by-zero faults, starting from an empty stack.
  task automatic test_faults_and_extremes();
    send_request(CMD_POP, Q_ZERO);         // pop on empty
    send_request(CMD_ADD, Q_ZERO);         // binary on empty
    send_request(CMD_PUSH, Q_FIVE);
    send_request(CMD_MUL, Q_ZERO);         // binary with one value: consumed
    send_request(CMD_PUSH, VAL_MAX);
    send_request(CMD_PUSH, VAL_MAX);
    send_request(CMD_ADD, Q_ZERO);         // saturates high
    send_request(CMD_PUSH, VAL_MIN);
    send_request(CMD_SUB, Q_ZERO);         // max minus min saturates high
    send_request(CMD_PUSH, VAL_MIN);
    send_request(CMD_ADD, Q_ZERO);         // max plus min, no clamp
    send_request(CMD_PUSH, Q_HALF);
    send_request(CMD_MUL, Q_ZERO);         // rounding tie lands on zero
    send_request(CMD_PUSH, Q_ZERO);
    send_request(CMD_DIV, Q_ZERO);         // divisor zero, both consumed
    send_request(CMD_PUSH, VAL_MIN);
    send_request(CMD_PUSH, Q_LSB_NEG);
    send_request(CMD_DIV, Q_ZERO);         // quotient saturates
    send_request(CMD_PUSH, VAL_MIN);
    send_request(CMD_MUL, Q_ZERO);         // product saturates low
    send_request(CMD_SPARE_LO, $urandom);
    send_request(CMD_SPARE_HI, $urandom);
    send_request(CMD_PUSH, 32'sd3);
    send_request(CMD_POP, $urandom);       // push_value must be ignored
    send_request(CMD_POP, $urandom);
  endtask

  // Fill the stack while the receiver holds off for a long time, so the
  // block backs up and stalls its input; then overflow and drain to empty.
  task automatic test_full_stack();
    hold_cycles = HOLD_CYCLES;
    while (calc_depth < STACK_DEPTH) send_request(CMD_PUSH, random_q16());
    send_request(CMD_PUSH, random_q16());  // push on full
    send_request(CMD_PUSH, random_q16());
    while (calc_depth > 0) send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);       // pop on empty again
  endtask

  // Random command mix kept near balance so the stack stays populated, with
  // periodic no-idle stretches.
  task automatic test_random_mix();
    int          sent;
    int          pick;
    logic [2:0]  cmd;
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      calm = ((sent % 250) >= 200);
      pick = $urandom_range(0, 99);
      if (calc_depth >= STACK_DEPTH - 2 && pick < 50 && $urandom_range(0, 1))
        pick = 50 + $urandom_range(0, 49);
      if (pick < 50)      cmd = CMD_PUSH;
      else if (pick < 58) cmd = CMD_POP;
      else if (pick < 68) cmd = CMD_ADD;
      else if (pick < 78) cmd = CMD_SUB;
      else if (pick < 88) cmd = CMD_MUL;
      else if (pick < 98) cmd = CMD_DIV;
      else if (pick < 99) cmd = CMD_SPARE_LO;
      else                cmd = CMD_SPARE_HI;
      send_request(cmd, (cmd == CMD_PUSH) ? random_q16() : $urandom);
      if (cmd <= CMD_DIV) sent++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_faults_and_extremes();
    test_full_stack();
    test_random_mix();
    in_valid <= 1'b0;
    // wait for every outstanding response, then watch for strays
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("stack_calculator_engine_unit regression: pass");
    end else begin
      $display("stack_calculator_engine_unit regression: fail");
    end
    $finish;
  end

endmodule
